>>> rtl/tlca_pkg.sv
// Package for the tree LCA engine: sizes, function codes, state encodings.
// No dependencies.
package tlca_pkg;
    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int DW = LOG_LEVELS + 1;
    localparam int AW = NW + LW;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_PAIR   = 2'd1,
        FUNC_TRIPLE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_BJ_RD1, ST_BJ_RD2, ST_BJ_WR,
        ST_DP_INIT, ST_DP_RD, ST_DP_STEP, ST_DP_WR,
        ST_Q_START, ST_Q_DA, ST_Q_DB, ST_Q_LIFT_RD, ST_Q_LIFT,
        ST_Q_CMP, ST_Q_SRCH_RDA, ST_Q_SRCH_RDB, ST_Q_SRCH,
        ST_Q_PAR_RD, ST_Q_PAR, ST_Q_DC, ST_Q_DC2, ST_Q_NEXT, ST_OUT
    } state_t;
endpackage

>>> rtl/tree_lca_binary_lifting.sv
// Top level of the tree LCA engine: sequencer, jump table and depth memories.
// Depends on tlca_pkg.
//
//  channel | dir | tdata fields (low bit up)            | tuser     | tlast
//  s_      | in  | node_a node_b node_c (32 bits)       | func[1:0] | last_load
//  m_      | out | ancestor path_nodes overlap (32 bits)| error     | -
//
// A pair query runs one pass of depth reads, lift, compare and, unless the nodes already
// meet, search and parent read; a triple query runs three passes, one for each pair.
// The search reads the entries of a and b for a level before it compares them.
// Reset clears only control and the built flag; no clearing pass.
// The block takes one word at a time; a result holds until m_tready.
module tree_lca_binary_lifting import tlca_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // node_a[9:0], node_b[19:10], node_c[29:20]
    input  logic [1:0]  s_tuser,   // func[1:0]
    input  logic        s_tlast,   // last_load
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ancestor[9:0], path_nodes[20:10], overlap[31:21]
    output logic        m_tuser    // error
);
    logic [NW-1:0] jmem [0:LOG_LEVELS*MAX_NODES-1];
    logic [DW-1:0] dmem [0:MAX_NODES-1];
    logic [NW-1:0] jrd_reg;
    logic [DW-1:0] drd_reg;
    logic          jwe, dwe;
    logic [AW-1:0] jra, jwa;
    logic [NW-1:0] jwd, dra, dwa;
    logic [DW-1:0] dwd;

    always_ff @(posedge aclk) begin
        if (jwe) jmem[jwa] <= jwd;
        jrd_reg <= jmem[jra];
        if (dwe) dmem[dwa] <= dwd;
        drd_reg <= dmem[dra];
    end

    function automatic logic [AW-1:0] ja(input logic [LW-1:0] l, input logic [NW-1:0] n);
        ja = AW'(l * MAX_NODES + n);
    endfunction

    state_t st_reg, st_next;
    logic built_reg, built_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [NW-1:0] j_reg, j_next, x_reg, x_next, a_reg, a_next, b_reg, b_next, t_reg, t_next;
    logic [DW-1:0] d_reg, d_next, da_reg, da_next, db_reg, db_next;
    logic [1:0]    func_reg, func_next, ph_reg, ph_next;
    logic [NW-1:0] qa_reg, qa_next, qb_reg, qb_next, qc_reg, qc_next;
    logic [DW-1:0] diff_reg, diff_next;
    logic [NW-1:0] anc_reg, anc_next;
    logic [13:0]   ds_reg [0:1];
    logic [13:0]   ds_next [0:1];
    logic [13:0]   dist_w;
    logic [14:0]   cal_w [0:2];
    logic [13:0]   m_w;
    logic          err_reg, err_next;
    logic [NW-1:0] o_anc_reg, o_anc_next;
    logic [10:0]   o_path_reg, o_path_next, o_ov_reg, o_ov_next;
    logic [DW-1:0] dc_reg, dc_next;

    logic [1:0]    s_func;
    logic [NW-1:0] s_a, s_b, s_c;
    assign s_func = s_tuser;
    assign s_a = s_tdata[0 +: NW];
    assign s_b = s_tdata[NW +: NW];
    assign s_c = s_tdata[2*NW +: NW];

    function automatic logic bad(input logic [NW-1:0] n);
        bad = (n == '0);
    endfunction

    function automatic logic [10:0] clamp(input logic [14:0] v);
        if (v[14]) clamp = '0;
        else if (v > 15'd2047) clamp = 11'd2047;
        else clamp = v[10:0];
    endfunction

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = {o_ov_reg, o_path_reg, o_anc_reg};
    assign m_tuser  = err_reg;

    // dist = da + db - 2*dc + 1 (signed)
    assign dist_w = 14'(da_reg) + 14'(db_reg) - 14'(dc_reg) - 14'(dc_reg) + 14'd1;
    always_comb begin
        cal_w[0] = 15'($signed(ds_reg[0])) + 15'($signed(ds_reg[1]))
                 - 15'($signed(dist_w)) + 15'sd1;
        cal_w[1] = 15'($signed(ds_reg[0])) + 15'($signed(dist_w))
                 - 15'($signed(ds_reg[1])) + 15'sd1;
        cal_w[2] = 15'($signed(ds_reg[1])) + 15'($signed(dist_w))
                 - 15'($signed(ds_reg[0])) + 15'sd1;
        for (int k = 0; k < 3; k++)
            if (cal_w[k][14]) cal_w[k] = '0;
            else cal_w[k] = {1'b0, cal_w[k][14:1]};
        m_w = cal_w[0][13:0];
        if (cal_w[1][13:0] > m_w) m_w = cal_w[1][13:0];
        if (cal_w[2][13:0] > m_w) m_w = cal_w[2][13:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            built_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            built_reg <= built_next;
        end
        lv_reg <= lv_next; j_reg <= j_next; x_reg <= x_next; a_reg <= a_next;
        b_reg <= b_next; t_reg <= t_next; d_reg <= d_next; da_reg <= da_next;
        db_reg <= db_next; func_reg <= func_next; ph_reg <= ph_next;
        qa_reg <= qa_next; qb_reg <= qb_next; qc_reg <= qc_next;
        diff_reg <= diff_next; anc_reg <= anc_next; err_reg <= err_next;
        o_anc_reg <= o_anc_next; o_path_reg <= o_path_next; o_ov_reg <= o_ov_next;
        dc_reg <= dc_next;
        for (int k = 0; k < 2; k++) ds_reg[k] <= ds_next[k];
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (s_tvalid) begin
                if (s_func == FUNC_LOAD) begin
                    if (s_tlast) st_next = (LOG_LEVELS > 1) ? ST_BJ_RD1 : ST_DP_INIT;
                end else if (s_func != FUNC_NONE) begin
                    if (!built_reg || bad(s_a) || bad(s_b)
                        || (s_func == FUNC_TRIPLE && bad(s_c))) st_next = ST_OUT;
                    else st_next = ST_Q_START;
                end
            end
            ST_BJ_RD1: st_next = ST_BJ_RD2;
            ST_BJ_RD2: st_next = ST_BJ_WR;
            ST_BJ_WR: if (j_reg == NW'(MAX_NODES - 1)) begin
                st_next = (lv_reg == LW'(LOG_LEVELS - 1)) ? ST_DP_INIT : ST_BJ_RD1;
            end else st_next = ST_BJ_RD1;
            ST_DP_INIT: st_next = ST_DP_RD;
            ST_DP_RD:   st_next = ST_DP_STEP;
            ST_DP_STEP: st_next = (lv_reg == '0) ? ST_DP_WR : ST_DP_RD;
            ST_DP_WR:   st_next = (j_reg == NW'(MAX_NODES - 1)) ? ST_IDLE : ST_DP_INIT;
            ST_Q_START: st_next = ST_Q_DA;
            ST_Q_DA:    st_next = ST_Q_DB;
            ST_Q_DB:    st_next = ST_Q_LIFT_RD;
            ST_Q_LIFT_RD: st_next = ST_Q_LIFT;
            ST_Q_LIFT:  st_next = (lv_reg == LW'(LOG_LEVELS - 1)) ? ST_Q_CMP : ST_Q_LIFT_RD;
            ST_Q_CMP:   st_next = (a_reg == b_reg) ? ST_Q_DC : ST_Q_SRCH_RDA;
            ST_Q_SRCH_RDA: st_next = ST_Q_SRCH_RDB;
            ST_Q_SRCH_RDB: st_next = ST_Q_SRCH;
            ST_Q_SRCH:  st_next = (lv_reg == '0) ? ST_Q_PAR_RD : ST_Q_SRCH_RDA;
            ST_Q_PAR_RD: st_next = ST_Q_PAR;
            ST_Q_PAR:   st_next = ST_Q_DC;
            ST_Q_DC:    st_next = ST_Q_DC2;
            ST_Q_DC2:   st_next = ST_Q_NEXT;
            ST_Q_NEXT:  st_next = (func_reg == FUNC_TRIPLE && ph_reg != 2'd2)
                                  ? ST_Q_START : ST_OUT;
            ST_OUT:     if (m_tready) st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        built_next = built_reg; lv_next = lv_reg; j_next = j_reg; x_next = x_reg;
        a_next = a_reg; b_next = b_reg; t_next = t_reg; d_next = d_reg;
        da_next = da_reg; db_next = db_reg; func_next = func_reg; ph_next = ph_reg;
        qa_next = qa_reg; qb_next = qb_reg; qc_next = qc_reg; diff_next = diff_reg;
        anc_next = anc_reg; err_next = err_reg; o_anc_next = o_anc_reg;
        o_path_next = o_path_reg; o_ov_next = o_ov_reg; dc_next = dc_reg;
        for (int k = 0; k < 2; k++) ds_next[k] = ds_reg[k];
        jwe = 1'b0; jwa = '0; jwd = '0; jra = '0;
        dwe = 1'b0; dwa = '0; dwd = '0; dra = '0;
        unique case (st_reg)
            ST_IDLE: if (s_tvalid) begin
                func_next = s_func; qa_next = s_a; qb_next = s_b; qc_next = s_c;
                ph_next = '0;
                o_anc_next = '0; o_path_next = '0; o_ov_next = '0; err_next = 1'b1;
                if (s_func == FUNC_LOAD) begin
                    built_next = 1'b0;
                    if (!bad(s_a)) begin
                        jwe = 1'b1; jwa = ja('0, s_a); jwd = s_b;
                    end
                    lv_next = LW'(1); j_next = '0;
                end else if (built_reg && !bad(s_a) && !bad(s_b)
                             && !(s_func == FUNC_TRIPLE && bad(s_c))) err_next = 1'b0;
            end
            ST_BJ_RD1: begin
                if (lv_reg == LW'(1) && j_reg == '0) begin
                    jwe = 1'b1; jwa = ja('0, '0); jwd = '0;
                end
                jra = ja(lv_reg - LW'(1), j_reg);
            end
            ST_BJ_RD2: jra = ja(lv_reg - LW'(1), jrd_reg);
            ST_BJ_WR: begin
                jwe = 1'b1; jwa = ja(lv_reg, j_reg);
                jwd = (j_reg == '0) ? '0 : jrd_reg;
                j_next = j_reg + NW'(1);
                if (j_reg == NW'(MAX_NODES - 1)) lv_next = lv_reg + LW'(1);
            end
            ST_DP_INIT: begin
                if (j_reg == '0) j_next = NW'(1);
                x_next = (j_reg == '0) ? NW'(1) : j_reg;
                d_next = '0; lv_next = LW'(LOG_LEVELS - 1);
                dwe = (j_reg == '0); dwa = '0; dwd = '0;
            end
            ST_DP_RD: jra = ja(lv_reg, x_reg);
            ST_DP_STEP: begin
                if (jrd_reg != '0) begin
                    x_next = jrd_reg; d_next = d_reg + (DW'(1) << lv_reg);
                end
                lv_next = lv_reg - LW'(1);
            end
            ST_DP_WR: begin
                dwe = 1'b1; dwa = j_reg; dwd = d_reg + DW'(1);
                j_next = j_reg + NW'(1);
                if (j_reg == NW'(MAX_NODES - 1)) built_next = 1'b1;
            end
            ST_Q_START: begin
                unique case (ph_reg)
                    2'd0:    begin a_next = qa_reg; b_next = qb_reg; end
                    2'd1:    begin a_next = qa_reg; b_next = qc_reg; end
                    default: begin a_next = qb_reg; b_next = qc_reg; end
                endcase
                if (func_reg == FUNC_PAIR) begin a_next = qa_reg; b_next = qb_reg; end
                dra = a_next;
            end
            ST_Q_DA: begin da_next = drd_reg; dra = b_reg; end
            ST_Q_DB: begin
                db_next = drd_reg;
                if (da_reg < drd_reg) begin
                    a_next = b_reg; b_next = a_reg; diff_next = drd_reg - da_reg;
                end else diff_next = da_reg - drd_reg;
                lv_next = '0;
            end
            ST_Q_LIFT_RD: jra = ja(lv_reg, a_reg);
            ST_Q_LIFT: begin
                if (diff_reg[lv_reg]) a_next = jrd_reg;
                lv_next = lv_reg + LW'(1);
            end
            ST_Q_CMP: begin
                anc_next = a_reg; lv_next = LW'(LOG_LEVELS - 1);
            end
            ST_Q_SRCH_RDA: jra = ja(lv_reg, a_reg);
            ST_Q_SRCH_RDB: begin jra = ja(lv_reg, b_reg); t_next = jrd_reg; end
            ST_Q_SRCH: begin
                if (t_reg != jrd_reg) begin a_next = t_reg; b_next = jrd_reg; end
                lv_next = lv_reg - LW'(1);
            end
            ST_Q_PAR_RD: jra = ja('0, a_reg);
            ST_Q_PAR: anc_next = jrd_reg;
            ST_Q_DC: dra = anc_reg;
            ST_Q_DC2: dc_next = drd_reg;
            ST_Q_NEXT: begin
                if (ph_reg != 2'd2) ds_next[ph_reg[0]] = dist_w;
                ph_next = ph_reg + 2'd1;
                if (func_reg == FUNC_PAIR) begin
                    o_anc_next = anc_reg;
                    o_path_next = clamp({dist_w[13], dist_w});
                end else if (ph_reg == 2'd2) begin
                    o_ov_next = clamp({1'b0, m_w});
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end
endmodule

>>> bench/tlca_checker.sv
// Scoreboard for the tree LCA engine: mirrors the jump table and depths, predicts each
// query word and compares the result channel. Depends on tlca_pkg.
module tlca_checker import tlca_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // node_a[9:0], node_b[19:10], node_c[29:20]
    input  logic [1:0]  s_tuser,   // func[1:0]
    input  logic        s_tlast,   // last_load
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // ancestor[9:0], path_nodes[20:10], overlap[31:21]
    input  logic        m_tuser,   // error
    output int          fails,
    output int          pending,
    output int          n_pair,
    output int          n_triple,
    output int          n_err,
    output int          n_builds
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NW-1:0] anc;
        logic [10:0]   path;
        logic [10:0]   ovl;
        logic          err;
    } lca_res_t;

    logic [NW-1:0] lift_tab [LOG_LEVELS][MAX_NODES];
    int unsigned   node_dep [MAX_NODES];
    bit            tree_ok;
    lca_res_t      due_q [$];

    assign pending = due_q.size();

    function automatic void rebuild();
        int unsigned x, d;
        lift_tab[0][0] = '0;
        for (int l = 1; l < LOG_LEVELS; l++)
            for (int j = 0; j < MAX_NODES; j++)
                lift_tab[l][j] = lift_tab[l-1][lift_tab[l-1][j]];
        node_dep[0] = 0;
        for (int j = 1; j < MAX_NODES; j++) begin
            x = j;
            d = 0;
            for (int l = LOG_LEVELS - 1; l >= 0; l--) begin
                if (lift_tab[l][x] != 0) begin
                    x = lift_tab[l][x];
                    d += 1 << l;
                end
            end
            node_dep[j] = d + 1;
        end
        tree_ok = 1'b1;
    endfunction

    function automatic int unsigned meet(int unsigned a, int unsigned b);
        int unsigned t, diff;
        if (node_dep[a] < node_dep[b]) begin
            t = a;
            a = b;
            b = t;
        end
        diff = node_dep[a] - node_dep[b];
        for (int l = 0; l < LOG_LEVELS; l++)
            if ((diff >> l) & 1) a = lift_tab[l][a];
        if (a == b) return a;
        for (int l = LOG_LEVELS - 1; l >= 0; l--) begin
            if (lift_tab[l][a] != lift_tab[l][b]) begin
                a = lift_tab[l][a];
                b = lift_tab[l][b];
            end
        end
        return lift_tab[0][a];
    endfunction

    function automatic longint span(int unsigned a, int unsigned b);
        int unsigned c;
        c = meet(a, b);
        return longint'(node_dep[a]) + longint'(node_dep[b]) - 2 * longint'(node_dep[c]) + 1;
    endfunction

    function automatic longint shared(int unsigned f, int unsigned s, int unsigned t);
        longint v;
        v = span(f, s) + span(f, t) - span(s, t) + 1;
        return (v < 0) ? 0 : v / 2;
    endfunction

    function automatic logic [10:0] sat11(longint v);
        if (v < 0) return '0;
        if (v > 2047) return 11'd2047;
        return v[10:0];
    endfunction

    function automatic bit bad(int unsigned n);
        return n == 0 || n >= MAX_NODES;
    endfunction

    always @(posedge aclk) begin
        func_t       fn;
        int unsigned a, b, c;
        longint      m, v;
        lca_res_t    r, got;
        if (!aresetn) begin
            tree_ok = 1'b0;
            due_q.delete();
            for (int l = 0; l < LOG_LEVELS; l++)
                for (int j = 0; j < MAX_NODES; j++)
                    lift_tab[l][j] = '0;
            for (int j = 0; j < MAX_NODES; j++) node_dep[j] = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                fn = func_t'(s_tuser);
                a = 32'(s_tdata[9:0]);
                b = 32'(s_tdata[19:10]);
                c = 32'(s_tdata[29:20]);
                r = '0;
                if (fn == FUNC_LOAD) begin
                    if (!bad(a)) lift_tab[0][a] = b[NW-1:0];
                    tree_ok = 1'b0;
                    if (s_tlast) begin
                        rebuild();
                        n_builds++;
                    end
                end else if (fn != FUNC_NONE) begin
                    if (!tree_ok || bad(a) || bad(b) || (fn == FUNC_TRIPLE && bad(c))) begin
                        r.err = 1'b1;
                        n_err++;
                    end else if (fn == FUNC_PAIR) begin
                        r.anc = NW'(meet(a, b));
                        r.path = sat11(span(a, b));
                        n_pair++;
                    end else begin
                        m = shared(a, b, c);
                        v = shared(b, a, c);
                        if (v > m) m = v;
                        v = shared(c, b, a);
                        if (v > m) m = v;
                        r.ovl = sat11(m);
                        n_triple++;
                    end
                    due_q.insert(due_q.size(), r);
                end
            end
            if (m_tvalid && m_tready) begin
                got.anc  = m_tdata[9:0];
                got.path = m_tdata[20:10];
                got.ovl  = m_tdata[31:21];
                got.err  = m_tuser;
                if (due_q.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    fails++;
                end else begin
                    r = due_q.pop_front();
                    if (got.anc != r.anc) begin
                        $error("ancestor: expected %0d, got %0d", r.anc, got.anc);
                        fails++;
                    end
                    if (got.path != r.path) begin
                        $error("path_nodes: expected %0d, got %0d", r.path, got.path);
                        fails++;
                    end
                    if (got.ovl != r.ovl) begin
                        $error("overlap: expected %0d, got %0d", r.ovl, got.ovl);
                        fails++;
                    end
                    if (got.err != r.err) begin
                        $error("error: expected %0d, got %0d", r.err, got.err);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

>>> bench/tb_tree_lca_binary_lifting.sv
// Top of the tree LCA engine bench: clock, reset, stimulus of tree loads and queries,
// verdict. Depends on tlca_pkg, tlca_checker and the tree_lca_binary_lifting RTL.
module tb_tree_lca_binary_lifting;
    import tlca_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int fails, pending, n_pair, n_triple, n_err, n_builds;
    int cycles = 0;
    bit quiet = 1'b0;
    bit calm = 1'b0;
    int unsigned tree_par [MAX_NODES];

    always #6 aclk = ~aclk;

    tree_lca_binary_lifting dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    tlca_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fails(fails), .pending(pending), .n_pair(n_pair), .n_triple(n_triple),
        .n_err(n_err), .n_builds(n_builds)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send_word(func_t fn, int unsigned a, int unsigned b, int unsigned c,
                             bit last);
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, c[9:0], b[9:0], a[9:0]};
        s_tuser <= fn;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_tree(bit close_on_zero);
        for (int j = 1; j < MAX_NODES; j++)
            send_word(FUNC_LOAD, j, tree_par[j], $urandom_range(0, 1023),
                      !close_on_zero && j == MAX_NODES - 1);
        if (close_on_zero) send_word(FUNC_LOAD, 0, $urandom_range(0, 1023), 0, 1'b1);
    endtask

    function automatic int unsigned pick_node();
        return $urandom_range(1, MAX_NODES - 1);
    endfunction

    function automatic int unsigned near_node(int unsigned n);
        int steps;
        steps = $urandom_range(0, 40);
        for (int k = 0; k < steps && tree_par[n] != 0; k++) n = tree_par[n];
        return n;
    endfunction

    task automatic random_queries(int count);
        int unsigned a, b, c;
        int sel;
        for (int k = 0; k < count; k++) begin
            a = pick_node();
            b = ($urandom_range(0, 2) == 0) ? near_node(a) : pick_node();
            c = ($urandom_range(0, 2) == 0) ? near_node(b) : pick_node();
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                send_word(FUNC_NONE, a, b, c, 1'($urandom_range(0, 1)));
            end else if (sel < 10) begin
                case ($urandom_range(0, 2))
                    0: a = 0;
                    1: b = 0;
                    default: c = 0;
                endcase
                send_word(sel[0] ? FUNC_PAIR : FUNC_TRIPLE, a, b, c,
                          1'($urandom_range(0, 1)));
            end else begin
                send_word(sel < 55 ? FUNC_PAIR : FUNC_TRIPLE, a, b, c,
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int waited;
        int unsigned nd;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(FUNC_PAIR, 5, 6, 0, 1'b0);
        send_word(FUNC_TRIPLE, 1, 2, 3, 1'b1);
        send_word(FUNC_NONE, 1023, 1023, 1023, 1'b1);
        send_word(FUNC_LOAD, 0, 1023, 1023, 1'b0);

        // deepest tree: one chain from the root, closed by a load of the sentinel
        tree_par[0] = 0;
        tree_par[1] = 0;
        for (int j = 2; j < MAX_NODES; j++) tree_par[j] = j - 1;
        load_tree(1'b1);
        send_word(FUNC_PAIR, 1023, 1, 0, 1'b0);
        send_word(FUNC_PAIR, 1, 1, 1023, 1'b0);
        send_word(FUNC_PAIR, 1023, 1023, 0, 1'b0);
        send_word(FUNC_PAIR, 512, 1022, 0, 1'b0);
        send_word(FUNC_TRIPLE, 1, 512, 1023, 1'b0);
        send_word(FUNC_TRIPLE, 1023, 1023, 1023, 1'b0);
        send_word(FUNC_PAIR, 0, 7, 0, 1'b0);
        send_word(FUNC_PAIR, 7, 0, 0, 1'b0);
        send_word(FUNC_TRIPLE, 7, 8, 0, 1'b0);
        send_word(FUNC_TRIPLE, 0, 0, 0, 1'b0);
        random_queries(60);

        // bushier tree: hang random nodes higher up, with a query while it is loading
        calm = 1'b1;
        for (int k = 0; k < 60; k++) begin
            nd = $urandom_range(2, MAX_NODES - 1);
            tree_par[nd] = $urandom_range(1, nd - 1);
            send_word(FUNC_LOAD, nd, tree_par[nd], 0, 1'b0);
            if (k == 30) send_word(FUNC_PAIR, 3, 4, 0, 1'b0);
        end
        nd = $urandom_range(2, MAX_NODES - 1);
        tree_par[nd] = $urandom_range(1, nd - 1);
        send_word(FUNC_LOAD, nd, tree_par[nd], 0, 1'b1);
        calm = 1'b0;
        random_queries(80);

        // malformed: a two-node loop, a self loop and a second tree hung off the sentinel
        tree_par[700] = 900;
        tree_par[900] = 700;
        tree_par[50] = 50;
        tree_par[300] = 0;
        send_word(FUNC_LOAD, 700, 900, 0, 1'b0);
        send_word(FUNC_LOAD, 900, 700, 0, 1'b0);
        send_word(FUNC_LOAD, 50, 50, 0, 1'b0);
        send_word(FUNC_LOAD, 300, 0, 0, 1'b1);
        send_word(FUNC_PAIR, 700, 900, 0, 1'b0);
        send_word(FUNC_PAIR, 50, 300, 0, 1'b0);
        send_word(FUNC_TRIPLE, 700, 50, 300, 1'b0);
        random_queries(60);

        // wide fan: the top block of nodes become children of the root
        for (int j = MAX_NODES - 40; j < MAX_NODES; j++) begin
            tree_par[j] = 1;
            send_word(FUNC_LOAD, j, 1, 0, j == MAX_NODES - 1);
        end
        random_queries(50);
        quiet = 1'b1;
        random_queries(40);

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (400) @(posedge aclk);
        $display("covered %0d tree builds, %0d pair and %0d triple queries, %0d error results",
                 n_builds, n_pair, n_triple, n_err);
        if (fails == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
